### src/matrix_inverse_adjugate_macros.svh
// Assertion macros shared by the matrix inverse block.
// Included by the top level; no other dependencies.
`ifndef MATRIX_INVERSE_ADJUGATE_MACROS_SVH
`define MATRIX_INVERSE_ADJUGATE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define MIA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("implication check failed");
// Next-cycle implication.
`define MIA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define MIA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MIA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### src/mia_pkg.sv
// Package of the matrix inverse block: widths, limits, sequencer states, helpers.
// No dependencies.
package mia_pkg;

	localparam int MAX_ORDER = 8;
	localparam int ELEM_W    = 32;
	localparam int SIZE_W    = 4;
	localparam int WORD_W    = 48;

	// Largest working magnitude, 2^47 - 1.
	localparam logic [46:0] WLIM = '1;
	localparam logic [47:0] ONE_Q16 = 48'h0000_0001_0000;

	typedef enum logic [26:0] {
		S_LOAD     = 27'd1 << 0,
		S_CP_RD    = 27'd1 << 1,
		S_CP_WR    = 27'd1 << 2,
		S_DET_INIT = 27'd1 << 3,
		S_PV_START = 27'd1 << 4,
		S_PV_RD    = 27'd1 << 5,
		S_PV_CMP   = 27'd1 << 6,
		S_PV_END   = 27'd1 << 7,
		S_SW_RA    = 27'd1 << 8,
		S_SW_RB    = 27'd1 << 9,
		S_SW_WA    = 27'd1 << 10,
		S_SW_WB    = 27'd1 << 11,
		S_DM       = 27'd1 << 12,
		S_DM_DONE  = 27'd1 << 13,
		S_EL_RD    = 27'd1 << 14,
		S_EL_DIV   = 27'd1 << 15,
		S_EL_K     = 27'd1 << 16,
		S_EL_RA    = 27'd1 << 17,
		S_EL_MUL   = 27'd1 << 18,
		S_EL_RB    = 27'd1 << 19,
		S_EL_WR    = 27'd1 << 20,
		S_DET_END  = 27'd1 << 21,
		S_MINOR    = 27'd1 << 22,
		S_OUT_SET  = 27'd1 << 23,
		S_OUT_WAIT = 27'd1 << 24,
		S_MUL      = 27'd1 << 25,
		S_DIV      = 27'd1 << 26
	} state_t;

	function automatic logic [47:0] mag48(input logic [47:0] x);
		return x[47] ? (~x + 48'd1) : x;
	endfunction

	// Saturating subtract of two working values, clamped to +-WLIM.
	function automatic logic [47:0] sat_sub(input logic [47:0] a, input logic [47:0] b);
		logic signed [48:0] d;
		logic signed [48:0] lim;
		d   = {a[47], a} - {b[47], b};
		lim = {2'b00, WLIM};
		if (d > lim) return lim[47:0];
		if (d < -lim) return 48'(-lim);
		return d[47:0];
	endfunction

endpackage

### src/matrix_inverse_adjugate.sv
// Top level of the fixed-point matrix inverse (adjugate over determinant).
// Depends on mia_pkg, mia_ram and matrix_inverse_adjugate_macros.svh.
//
//   Channel  Signals                          Dir  Contents
//   in       in_valid/in_ready, element        in   one Q16.16 matrix element, row-major
//   out      out_valid/out_ready, value,       out  one inverse element, or the singular
//            singular, last                         marker; last flags the final beat
//   cfg      cfg_write_en, matrix_size         in   matrix order n, written at once
//
// After the last element the sequencer computes the determinant and then, for each
// output, one cofactor and one quotient, all on one shared 24x24 multiplier and one
// radix-2 divider, both fed from a simple dual-port work memory.
// in_ready is high only while loading; each result is held until out_ready.
// Reset selects order 4 and clears the load count; the memories need no clearing.
`include "matrix_inverse_adjugate_macros.svh"

module matrix_inverse_adjugate (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [mia_pkg::ELEM_W-1:0]  element,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [mia_pkg::ELEM_W-1:0]  value,
	output logic                               singular,
	output logic                               last,
	input  logic                               cfg_write_en,
	input  logic [mia_pkg::SIZE_W-1:0]         matrix_size
);
	import mia_pkg::*;

	// Control state.
	state_t      state_q, ret_q;
	logic [3:0]  size_q;
	logic [6:0]  load_cnt_q;
	logic        full_q;
	logic        flip_q;

	// Loop counters; row/column indexes use their low three bits.
	logic [3:0]  m_q, i_q, j_q, l_q, mr_q, mc_q;
	logic [3:0]  skip_row_q, skip_col_q, orow_q, ocol_q;
	logic [2:0]  p_q;

	// Working values, signed Q32.16 in 48 bits.
	logic [46:0] best_q;
	logic [47:0] piv_q, det_q, detf_q, k_q, tmp_q;

	// Shared multiplier.
	logic [47:0] ma_q, mb_q;
	logic        mneg_q;
	logic [1:0]  mcnt_q;
	logic [95:0] acc_q;

	// Shared divider.
	logic [63:0] dquo_q;
	logic [47:0] drem_q, dden_q;
	logic        dneg_q, dfin_q;
	logic [5:0]  dcnt_q;

	// Result register.
	logic [31:0] value_q;
	logic        sing_q, last_q;

	logic [3:0]  n_use;
	logic [6:0]  total;
	logic [3:0]  cp_row, cp_col;
	logic [6:0]  cp_addr;
	logic [31:0] mst_rd;
	logic [63:0] wk_rd;
	logic        wk_we;
	logic [5:0]  wk_waddr, wk_raddr;
	logic [63:0] wk_wdata;
	logic [47:0] wk_val, wk_mag;
	logic [23:0] a_half, b_half;
	logic [47:0] pp;
	logic [95:0] pp_sh;
	logic [79:0] msh;
	logic [46:0] mmag;
	logic [47:0] mul_res;
	logic [49:0] dtry;
	logic [63:0] lim_pos, lim_neg, dmag, div_res;
	logic [47:0] det_res, cof;
	logic [47:0] elim_res;
	logic        load_beat;

	// An order of zero acts as one; anything above the maximum is clamped.
	always_comb begin
		if (size_q == 4'd0) begin
			n_use = 4'd1;
		end else if (size_q > 4'(MAX_ORDER)) begin
			n_use = 4'(MAX_ORDER);
		end else begin
			n_use = size_q;
		end
	end
	assign total = 7'(n_use) * 7'(n_use);

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT_WAIT);
	assign value     = value_q;
	assign singular  = sing_q;
	assign last      = last_q;
	assign load_beat = in_valid && in_ready;

	// Copy addressing: skip the removed row and column of the minor. A skip index
	// of eight never matches, which gives the full-matrix copy.
	assign cp_row  = mr_q + ((mr_q >= skip_row_q) ? 4'd1 : 4'd0);
	assign cp_col  = mc_q + ((mc_q >= skip_col_q) ? 4'd1 : 4'd0);
	assign cp_addr = 7'(cp_row) * 7'(n_use) + 7'(cp_col);

	mia_ram #(.WIDTH(32), .DEPTH(64)) u_matrix_ram (
		.clk   (clk),
		.we    (load_beat),
		.waddr (load_cnt_q[5:0]),
		.wdata (element),
		.raddr (cp_addr[5:0]),
		.rdata (mst_rd)
	);

	mia_ram #(.WIDTH(64), .DEPTH(64)) u_work_ram (
		.clk   (clk),
		.we    (wk_we),
		.waddr (wk_waddr),
		.wdata (wk_wdata),
		.raddr (wk_raddr),
		.rdata (wk_rd)
	);

	assign wk_val = wk_rd[47:0];
	assign wk_mag = mag48(wk_val);

	// Multiplier: one 24x24 partial product per cycle, low halves first.
	assign a_half = mcnt_q[1] ? ma_q[47:24] : ma_q[23:0];
	assign b_half = mcnt_q[0] ? mb_q[47:24] : mb_q[23:0];
	assign pp     = a_half * b_half;
	always_comb begin
		case (mcnt_q)
			2'd0:    pp_sh = 96'(pp);
			2'd3:    pp_sh = 96'(pp) << 48;
			default: pp_sh = 96'(pp) << 24;
		endcase
	end
	assign msh     = acc_q[95:16];
	assign mmag    = (msh > 80'(WLIM)) ? WLIM : msh[46:0];
	assign mul_res = mneg_q ? -{1'b0, mmag} : {1'b0, mmag};

	// Divider: restoring, one quotient bit per cycle; the dividend shifts out
	// of the top of the quotient register as quotient bits shift in.
	assign dtry    = {1'b0, drem_q, dquo_q[63]} - {2'b00, dden_q};
	assign lim_pos = dfin_q ? 64'h7FFF_FFFF : 64'(WLIM);
	assign lim_neg = dfin_q ? 64'h8000_0000 : 64'(WLIM);
	always_comb begin
		if (dneg_q) begin
			dmag = (dquo_q > lim_neg) ? lim_neg : dquo_q;
		end else begin
			dmag = (dquo_q > lim_pos) ? lim_pos : dquo_q;
		end
	end
	assign div_res = dneg_q ? -dmag : dmag;

	assign det_res  = flip_q ? -det_q : det_q;
	assign cof      = (ocol_q[0] ^ orow_q[0]) ? -det_res : det_res;
	assign elim_res = sat_sub(wk_val, mul_res);

	// Work memory ports, driven by the sequencer state.
	always_comb begin
		wk_we    = 1'b0;
		wk_waddr = {mr_q[2:0], mc_q[2:0]};
		wk_wdata = {{32{mst_rd[31]}}, mst_rd};
		wk_raddr = {j_q[2:0], i_q[2:0]};
		case (state_q)
			S_CP_WR: begin
				wk_we = 1'b1;
			end
			S_SW_WA: begin
				wk_we    = 1'b1;
				wk_waddr = {i_q[2:0], l_q[2:0]};
				wk_wdata = wk_rd;
			end
			S_SW_WB: begin
				wk_we    = 1'b1;
				wk_waddr = {p_q, l_q[2:0]};
				wk_wdata = {{16{tmp_q[47]}}, tmp_q};
			end
			S_EL_WR: begin
				wk_we    = 1'b1;
				wk_waddr = {j_q[2:0], l_q[2:0]};
				wk_wdata = {{16{elim_res[47]}}, elim_res};
			end
			S_SW_RA, S_EL_RA: begin
				wk_raddr = {i_q[2:0], l_q[2:0]};
			end
			S_SW_RB: begin
				wk_raddr = {p_q, l_q[2:0]};
			end
			S_EL_RB: begin
				wk_raddr = {j_q[2:0], l_q[2:0]};
			end
			default: begin
			end
		endcase
	end

	// Sequencer. The first pass eliminates the whole matrix for the determinant;
	// each later pass copies one minor, eliminates it and divides by the
	// determinant, producing outputs in row-major order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			ret_q      <= S_LOAD;
			size_q     <= 4'd4;
			load_cnt_q <= '0;
			full_q     <= 1'b0;
			flip_q     <= 1'b0;
			m_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			l_q        <= '0;
			mr_q       <= '0;
			mc_q       <= '0;
			skip_row_q <= '0;
			skip_col_q <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			p_q        <= '0;
			best_q     <= '0;
			piv_q      <= '0;
			det_q      <= '0;
			detf_q     <= '0;
			k_q        <= '0;
			tmp_q      <= '0;
			ma_q       <= '0;
			mb_q       <= '0;
			mneg_q     <= 1'b0;
			mcnt_q     <= '0;
			acc_q      <= '0;
			dquo_q     <= '0;
			drem_q     <= '0;
			dden_q     <= '0;
			dneg_q     <= 1'b0;
			dfin_q     <= 1'b0;
			dcnt_q     <= '0;
			value_q    <= '0;
			sing_q     <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (load_cnt_q + 7'd1 == total) begin
							load_cnt_q <= '0;
							full_q     <= 1'b1;
							skip_row_q <= 4'd8;
							skip_col_q <= 4'd8;
							m_q        <= n_use;
							mr_q       <= '0;
							mc_q       <= '0;
							state_q    <= S_CP_RD;
						end else begin
							load_cnt_q <= load_cnt_q + 7'd1;
						end
					end
				end
				S_CP_RD: begin
					state_q <= S_CP_WR;
				end
				S_CP_WR: begin
					if (mc_q + 4'd1 == m_q) begin
						mc_q <= '0;
						if (mr_q + 4'd1 == m_q) begin
							state_q <= S_DET_INIT;
						end else begin
							mr_q    <= mr_q + 4'd1;
							state_q <= S_CP_RD;
						end
					end else begin
						mc_q    <= mc_q + 4'd1;
						state_q <= S_CP_RD;
					end
				end
				S_DET_INIT: begin
					i_q     <= '0;
					flip_q  <= 1'b0;
					det_q   <= ONE_Q16;
					state_q <= S_PV_START;
				end
				S_PV_START: begin
					if (i_q == m_q) begin
						state_q <= S_DET_END;
					end else begin
						j_q     <= i_q;
						best_q  <= '0;
						p_q     <= i_q[2:0];
						piv_q   <= '0;
						state_q <= S_PV_RD;
					end
				end
				S_PV_RD: begin
					state_q <= S_PV_CMP;
				end
				S_PV_CMP: begin
					// Strictly greater keeps the first row of equal magnitude.
					if (wk_mag > {1'b0, best_q}) begin
						best_q <= wk_mag[46:0];
						p_q    <= j_q[2:0];
						piv_q  <= wk_val;
					end
					if (j_q + 4'd1 == m_q) begin
						state_q <= S_PV_END;
					end else begin
						j_q     <= j_q + 4'd1;
						state_q <= S_PV_RD;
					end
				end
				S_PV_END: begin
					if (best_q == '0) begin
						det_q   <= '0;
						flip_q  <= 1'b0;
						state_q <= S_DET_END;
					end else if (p_q != i_q[2:0]) begin
						flip_q  <= ~flip_q;
						l_q     <= '0;
						state_q <= S_SW_RA;
					end else begin
						state_q <= S_DM;
					end
				end
				S_SW_RA: begin
					state_q <= S_SW_RB;
				end
				S_SW_RB: begin
					tmp_q   <= wk_val;
					state_q <= S_SW_WA;
				end
				S_SW_WA: begin
					state_q <= S_SW_WB;
				end
				S_SW_WB: begin
					if (l_q + 4'd1 == m_q) begin
						state_q <= S_DM;
					end else begin
						l_q     <= l_q + 4'd1;
						state_q <= S_SW_RA;
					end
				end
				S_DM: begin
					// The pivot is the final diagonal entry, so the running
					// determinant takes it now.
					ma_q    <= mag48(det_q);
					mb_q    <= mag48(piv_q);
					mneg_q  <= det_q[47] ^ piv_q[47];
					acc_q   <= '0;
					mcnt_q  <= '0;
					ret_q   <= S_DM_DONE;
					state_q <= S_MUL;
				end
				S_DM_DONE: begin
					det_q <= mul_res;
					if (i_q + 4'd1 == m_q) begin
						i_q     <= i_q + 4'd1;
						state_q <= S_PV_START;
					end else begin
						j_q     <= i_q + 4'd1;
						state_q <= S_EL_RD;
					end
				end
				S_EL_RD: begin
					state_q <= S_EL_DIV;
				end
				S_EL_DIV: begin
					dquo_q  <= {mag48(wk_val), 16'h0000};
					drem_q  <= '0;
					dden_q  <= mag48(piv_q);
					dneg_q  <= wk_val[47] ^ piv_q[47];
					dfin_q  <= 1'b0;
					dcnt_q  <= '0;
					ret_q   <= S_EL_K;
					state_q <= S_DIV;
				end
				S_EL_K: begin
					k_q     <= div_res[47:0];
					l_q     <= i_q;
					state_q <= S_EL_RA;
				end
				S_EL_RA: begin
					state_q <= S_EL_MUL;
				end
				S_EL_MUL: begin
					ma_q    <= mag48(k_q);
					mb_q    <= wk_mag;
					mneg_q  <= k_q[47] ^ wk_val[47];
					acc_q   <= '0;
					mcnt_q  <= '0;
					ret_q   <= S_EL_RB;
					state_q <= S_MUL;
				end
				S_EL_RB: begin
					state_q <= S_EL_WR;
				end
				S_EL_WR: begin
					if (l_q + 4'd1 == m_q) begin
						if (j_q + 4'd1 == m_q) begin
							i_q     <= i_q + 4'd1;
							state_q <= S_PV_START;
						end else begin
							j_q     <= j_q + 4'd1;
							state_q <= S_EL_RD;
						end
					end else begin
						l_q     <= l_q + 4'd1;
						state_q <= S_EL_RA;
					end
				end
				S_DET_END: begin
					if (full_q) begin
						if (det_res == '0) begin
							value_q <= '0;
							sing_q  <= 1'b1;
							last_q  <= 1'b1;
							state_q <= S_OUT_WAIT;
						end else begin
							detf_q  <= det_res;
							orow_q  <= '0;
							ocol_q  <= '0;
							state_q <= S_MINOR;
						end
					end else begin
						dquo_q  <= {mag48(cof), 16'h0000};
						drem_q  <= '0;
						dden_q  <= mag48(detf_q);
						dneg_q  <= cof[47] ^ detf_q[47];
						dfin_q  <= 1'b1;
						dcnt_q  <= '0;
						ret_q   <= S_OUT_SET;
						state_q <= S_DIV;
					end
				end
				S_MINOR: begin
					// Output (r, c) is cofactor (c, r): drop row c and column r.
					full_q     <= 1'b0;
					skip_row_q <= ocol_q;
					skip_col_q <= orow_q;
					m_q        <= n_use - 4'd1;
					mr_q       <= '0;
					mc_q       <= '0;
					state_q    <= (n_use == 4'd1) ? S_DET_INIT : S_CP_RD;
				end
				S_OUT_SET: begin
					value_q <= div_res[31:0];
					sing_q  <= 1'b0;
					last_q  <= (orow_q + 4'd1 == n_use) && (ocol_q + 4'd1 == n_use);
					state_q <= S_OUT_WAIT;
				end
				S_OUT_WAIT: begin
					if (out_ready) begin
						if (last_q) begin
							state_q <= S_LOAD;
						end else if (ocol_q + 4'd1 == n_use) begin
							ocol_q  <= '0;
							orow_q  <= orow_q + 4'd1;
							state_q <= S_MINOR;
						end else begin
							ocol_q  <= ocol_q + 4'd1;
							state_q <= S_MINOR;
						end
					end
				end
				S_MUL: begin
					acc_q  <= acc_q + pp_sh;
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) begin
						state_q <= ret_q;
					end
				end
				S_DIV: begin
					if (!dtry[49]) begin
						drem_q <= dtry[47:0];
						dquo_q <= {dquo_q[62:0], 1'b1};
					end else begin
						drem_q <= {drem_q[46:0], dquo_q[63]};
						dquo_q <= {dquo_q[62:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase

			// A register write discards any partial load.
			if (cfg_write_en) begin
				size_q     <= matrix_size;
				load_cnt_q <= '0;
			end
		end
	end

	`MIA_ASSERT_IMP(a_sing_last, clk, arst_n, out_valid && singular, last && (value == 32'sd0))
	`MIA_ASSERT_IMP(a_one_side, clk, arst_n, in_ready, !out_valid)
	`MIA_ASSERT_IMP(a_load_range, clk, arst_n, in_valid && in_ready, load_cnt_q < total)
	`MIA_ASSERT_NXT(a_mul_len, clk, arst_n, (state_q == S_MUL) && (mcnt_q != 2'd3), state_q == S_MUL)

endmodule

### src/mia_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
